// ===== rtl/sae_pkg.sv =====
// Shared widths, word types and request codes for the sortable array engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sae_pkg;

  // Default element store depth
  localparam int DEPTH_DEF  = 64;

  // Field widths of the request and response channels
  localparam int REQ_TYPE_W = 3;
  localparam int IDX_W      = 6;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [REQ_TYPE_W-1:0]    req_type_t;

  // Request codes
  localparam req_type_t REQ_WRITE     = 3'd0;
  localparam req_type_t REQ_READ      = 3'd1;
  localparam req_type_t REQ_RESIZE    = 3'd2;
  localparam req_type_t REQ_POP_BACK  = 3'd3;
  localparam req_type_t REQ_POP_HEAD  = 3'd4;
  localparam req_type_t REQ_SORT      = 3'd5;
  localparam req_type_t REQ_ERASE     = 3'd6;

endpackage

`default_nettype wire

// ===== rtl/sae_req_if.sv =====
// Request channel of the sortable array engine: valid/ready plus request fields.
// Depends on sae_pkg for field widths.
`default_nettype none

interface sae_req_if import sae_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [REQ_TYPE_W-1:0]   req_type;
  logic [IDX_W-1:0]        elem_index;
  logic signed [WORD_W-1:0] write_value;
  logic [LEN_W-1:0]        new_length;

  modport source (output valid, output req_type, output elem_index,
                  output write_value, output new_length, input ready);
  modport sink   (input valid, input req_type, input elem_index,
                  input write_value, input new_length, output ready);

endinterface

`default_nettype wire

// ===== rtl/sae_rsp_if.sv =====
// Response channel of the sortable array engine: valid/ready plus result fields.
// Depends on sae_pkg for field widths.
`default_nettype none

interface sae_rsp_if import sae_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [LEN_W-1:0]         cur_length;
  logic                     req_error;

  modport source (output valid, output read_value, output cur_length,
                  output req_error, input ready);
  modport sink   (input valid, input read_value, input cur_length,
                  input req_error, output ready);

endinterface

`default_nettype wire

// ===== rtl/sortable_array_engine.sv =====
// Top level of the sortable array engine: element memory, request sequencer
// and response register. Depends on sae_pkg, sae_req_if and sae_rsp_if.
//
//   channel   | direction | handshake   | carries
//   ----------+-----------+-------------+------------------------------------------
//   in_req    | in        | valid/ready | req_type, elem_index, write_value, new_length
//   out_rsp   | out       | valid/ready | read_value, cur_length, req_error
//
// Write, read, shrinking resize, pop back, erase and unused codes go from accept
// straight to the response state. A growing resize first writes the new tail,
// one zero write per cycle. Pop front moves one element per cycle down
// through the memory's read and write ports.
// Sort runs passes p = L-1 .. 1, each ending with the pass maximum parked, with
// one compare-and-write per cycle on the memory ports.
// Synchronous active-low reset clears the length and control; the memory is
// not cleared. A new request is accepted while an earlier result waits.
`default_nettype none

module sortable_array_engine import sae_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  sae_req_if.sink   in_req,
  sae_rsp_if.source out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_RESP       = 3'd1;
  localparam logic [2:0] S_FILL       = 3'd2;
  localparam logic [2:0] S_SHIFT      = 3'd3;
  localparam logic [2:0] S_SORT_PRIME = 3'd4;
  localparam logic [2:0] S_SORT_RUN   = 3'd5;
  localparam logic [2:0] S_SORT_END   = 3'd6;

  // Element memory
  word_t          elem_mem [DEPTH];
  word_t          mem_q_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  word_t          mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  // Control and working registers
  logic [2:0] state_r, state_nxt;
  len_t       len_r, len_nxt;
  len_t       k_r, k_nxt;
  len_t       bound_r, bound_nxt;
  word_t      carry_r, carry_nxt;
  logic       err_r, err_nxt;
  logic       rdsel_r, rdsel_nxt;

  // Response register
  logic       out_valid_r, out_valid_nxt;
  word_t      out_read_value_r, out_read_value_nxt;
  len_t       out_cur_length_r, out_cur_length_nxt;
  logic       out_req_error_r, out_req_error_nxt;

  logic       in_fire;
  logic       idx_ok;
  logic       carry_gt;

  assign in_req.ready       = (state_r == S_IDLE);
  assign in_fire            = in_req.valid && in_req.ready;
  assign idx_ok             = LEN_W'(in_req.elem_index) < len_r;
  assign carry_gt           = carry_r > mem_q_r;

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_value = out_read_value_r;
  assign out_rsp.cur_length = out_cur_length_r;
  assign out_rsp.req_error  = out_req_error_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= elem_mem[mem_raddr];
    end
  end

  // Sequencer: decode requests, walk the memory, stage the response
  always_comb begin
    state_nxt          = state_r;
    len_nxt            = len_r;
    k_nxt              = k_r;
    bound_nxt          = bound_r;
    carry_nxt          = carry_r;
    err_nxt            = err_r;
    rdsel_nxt          = rdsel_r;
    out_valid_nxt      = out_valid_r && !out_rsp.ready;
    out_read_value_nxt = out_read_value_r;
    out_cur_length_nxt = out_cur_length_r;
    out_req_error_nxt  = out_req_error_r;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = '0;
    mem_re             = 1'b0;
    mem_raddr          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          err_nxt   = 1'b0;
          rdsel_nxt = 1'b0;
          state_nxt = S_RESP;
          unique case (in_req.req_type)
            REQ_WRITE: begin
              if (idx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_req.elem_index);
                mem_wdata = in_req.write_value;
              end else begin
                err_nxt = 1'b1;
              end
            end
            REQ_READ: begin
              if (idx_ok) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_req.elem_index);
                rdsel_nxt = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            REQ_RESIZE: begin
              if (int'(in_req.new_length) > DEPTH) begin
                err_nxt = 1'b1;
              end else begin
                len_nxt = in_req.new_length;
                if (in_req.new_length > len_r) begin
                  k_nxt     = len_r;
                  bound_nxt = in_req.new_length;
                  state_nxt = S_FILL;
                end
              end
            end
            REQ_POP_BACK: begin
              if (len_r != '0) begin
                len_nxt = len_r - LEN_W'(1);
              end
            end
            REQ_POP_HEAD: begin
              if (len_r == '0) begin
                err_nxt = 1'b1;
              end else begin
                len_nxt = len_r - LEN_W'(1);
                if (len_r >= LEN_W'(2)) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(1);
                  k_nxt     = LEN_W'(1);
                  bound_nxt = len_r;
                  state_nxt = S_SHIFT;
                end
              end
            end
            REQ_SORT: begin
              if (len_r >= LEN_W'(2)) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                bound_nxt = len_r - LEN_W'(1);
                state_nxt = S_SORT_PRIME;
              end
            end
            REQ_ERASE: begin
              len_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Zero-fill the grown tail, one entry a cycle
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r);
        mem_wdata = '0;
        k_nxt     = k_r + LEN_W'(1);
        if (k_r + LEN_W'(1) == bound_r) begin
          state_nxt = S_RESP;
        end
      end

      // Move element k down one place, fetch the next
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r - LEN_W'(1));
        mem_wdata = mem_q_r;
        if (k_r + LEN_W'(1) < bound_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k_r + LEN_W'(1));
          k_nxt     = k_r + LEN_W'(1);
        end else begin
          state_nxt = S_RESP;
        end
      end

      // Load the first element of a pass as the running maximum
      S_SORT_PRIME: begin
        carry_nxt = mem_q_r;
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        k_nxt     = LEN_W'(1);
        state_nxt = S_SORT_RUN;
      end

      // Drop the smaller word one place back, carry the larger forward
      S_SORT_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k_r - LEN_W'(1));
        mem_wdata = carry_gt ? mem_q_r : carry_r;
        carry_nxt = carry_gt ? carry_r : mem_q_r;
        if (k_r < bound_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k_r + LEN_W'(1));
          k_nxt     = k_r + LEN_W'(1);
        end else begin
          state_nxt = S_SORT_END;
        end
      end

      // Park the pass maximum at the end of the pass, start the next pass
      S_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(bound_r);
        mem_wdata = carry_r;
        if (bound_r == LEN_W'(1)) begin
          state_nxt = S_RESP;
        end else begin
          bound_nxt = bound_r - LEN_W'(1);
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_SORT_PRIME;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt      = 1'b1;
          out_read_value_nxt = rdsel_r ? mem_q_r : '0;
          out_cur_length_nxt = len_r;
          out_req_error_nxt  = err_r;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    k_r              <= k_nxt;
    bound_r          <= bound_nxt;
    carry_r          <= carry_nxt;
    err_r            <= err_nxt;
    rdsel_r          <= rdsel_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_cur_length_r <= out_cur_length_nxt;
    out_req_error_r  <= out_req_error_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sae_checker.sv =====
// Port-level checks for the sortable array engine, bound to its top level.
// Depends on sae_pkg and on the ports of sortable_array_engine.
`default_nettype none

module sae_checker import sae_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [WORD_W-1:0] out_read_value,
  input wire [LEN_W-1:0]  out_cur_length,
  input wire              out_req_error
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("response without an outstanding request");

  a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("request accepted with two results outstanding");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_cur_length) <= DEPTH)
    else $error("reported length beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req_error |-> out_read_value == '0)
    else $error("refused request returned data");

endmodule

bind sortable_array_engine sae_checker #(.DEPTH(DEPTH)) u_sae_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_read_value (out_rsp.read_value),
  .out_cur_length (out_rsp.cur_length),
  .out_req_error  (out_rsp.req_error)
);

`default_nettype wire

// ===== verif/sae_checker.sv =====
`timescale 1ns / 100ps
// In-order result checker for the sortable array engine: keeps its own copy of
// the element store and length and checks each result as it is accepted.
// Depends on sae_pkg, sae_req_if and sae_rsp_if.
module sae_scoreboard import sae_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  sae_req_if          req_mon,
  sae_rsp_if          rsp_mon,
  output int unsigned fail_count,
  output int unsigned pending_rsp,
  output len_t        model_length,
  output int unsigned rsp_checked,
  output int unsigned refused_count,
  output int unsigned longest_sort
);

  typedef struct packed {
    word_t read_value;
    len_t  cur_length;
    logic  req_error;
  } array_result_t;

  word_t         shadow_store [DEPTH];
  len_t          shadow_len;
  array_result_t expected_q [$];

  // Apply one request to the shadow array and return the result it gives
  function automatic array_result_t apply_request(input req_type_t op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input word_t wval,
                                                  input len_t nlen);
    array_result_t res;
    word_t         swap;
    int            k;
    int            pass;
    res = '0;
    case (op)
      REQ_WRITE: begin
        if (idx < shadow_len) shadow_store[idx] = wval;
        else res.req_error = 1'b1;
      end
      REQ_READ: begin
        if (idx < shadow_len) res.read_value = shadow_store[idx];
        else res.req_error = 1'b1;
      end
      REQ_RESIZE: begin
        if (int'(nlen) > DEPTH) begin
          res.req_error = 1'b1;
        end else begin
          // zero-fill any new entries, keep the prefix otherwise
          for (k = int'(shadow_len); k < int'(nlen); k++) shadow_store[k] = '0;
          shadow_len = nlen;
        end
      end
      REQ_POP_BACK: begin
        if (shadow_len != 0) shadow_len = shadow_len - 1'b1;
      end
      REQ_POP_HEAD: begin
        if (shadow_len == 0) begin
          res.req_error = 1'b1;
        end else begin
          for (k = 1; k < int'(shadow_len); k++) shadow_store[k-1] = shadow_store[k];
          shadow_len = shadow_len - 1'b1;
        end
      end
      REQ_SORT: begin
        if (shadow_len > longest_sort) longest_sort = shadow_len;
        // ascending bubble sort on signed words
        for (pass = int'(shadow_len) - 1; pass > 0; pass--) begin
          for (k = 0; k < pass; k++) begin
            if (shadow_store[k] > shadow_store[k+1]) begin
              swap              = shadow_store[k];
              shadow_store[k]   = shadow_store[k+1];
              shadow_store[k+1] = swap;
            end
          end
        end
      end
      REQ_ERASE: shadow_len = '0;
      default: ;
    endcase
    res.cur_length = shadow_len;
    return res;
  endfunction

  // Check results first, then record the request accepted on the same edge
  always @(posedge clk) begin
    array_result_t got;
    array_result_t want;
    if (!rst_n) begin
      shadow_len = '0;
      expected_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = {rsp_mon.read_value, rsp_mon.cur_length, rsp_mon.req_error};
        rsp_checked++;
        if (got.req_error === 1'b1) refused_count++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: read_value %0d, cur_length %0d",
                 $signed(got.read_value), got.cur_length);
          fail_count++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(want.read_value), $signed(got.read_value));
            fail_count++;
          end
          if (got.cur_length !== want.cur_length) begin
            $error("cur_length: expected %0d, got %0d", want.cur_length, got.cur_length);
            fail_count++;
          end
          if (got.req_error !== want.req_error) begin
            $error("req_error: expected %0b, got %0b", want.req_error, got.req_error);
            fail_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_q.push_back(apply_request(req_mon.req_type, req_mon.elem_index,
                                           req_mon.write_value, req_mon.new_length));
      end
    end
    pending_rsp  = expected_q.size();
    model_length = shadow_len;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sortable array engine testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on sae_pkg, sae_req_if, sae_rsp_if,
// sae_scoreboard and sortable_array_engine.
module testbench;
  import sae_pkg::*;

  localparam int          DEPTH        = DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1500;
  localparam req_type_t   REQ_UNUSED   = 3'd7;
  // Every request a full-depth sort with long result stalls, then several times over
  localparam int unsigned CYCLE_LIMIT  = 16_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_rsp;
  int unsigned rsp_checked;
  int unsigned refused_count;
  int unsigned longest_sort;
  len_t        model_length;
  int unsigned op_count [8];
  int unsigned cycle_count;
  int unsigned ready_left;
  int unsigned ready_mode;

  sae_req_if req_bus ();
  sae_rsp_if rsp_bus ();

  sortable_array_engine #(.DEPTH(DEPTH)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  sae_scoreboard #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_bus),
    .rsp_mon       (rsp_bus),
    .fail_count    (fail_count),
    .pending_rsp   (pending_rsp),
    .model_length  (model_length),
    .rsp_checked   (rsp_checked),
    .refused_count (refused_count),
    .longest_sort  (longest_sort)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_rsp);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Back-pressure: switch between free flow, random stalls and long stalls
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(16, 160);
    end
    ready_left--;
    case (ready_mode)
      0:       rsp_bus.ready = 1'b1;
      1:       rsp_bus.ready = ($urandom_range(0, 1) != 0);
      default: rsp_bus.ready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Present one request and hold it until it is taken
  task automatic send_req(input req_type_t op, input logic [IDX_W-1:0] idx,
                          input word_t wval, input len_t nlen);
    @(negedge clk);
    req_bus.valid       = 1'b1;
    req_bus.req_type    = op;
    req_bus.elem_index  = idx;
    req_bus.write_value = wval;
    req_bus.new_length  = nlen;
    op_count[op]++;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic hold_idle(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_bus.valid = 1'b0;
    end
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_rsp != 0) @(negedge clk);
  endtask

  initial begin
    req_type_t        op;
    logic [IDX_W-1:0] idx;
    word_t            wval;
    len_t             nlen;
    int unsigned      burst_left;
    int unsigned      pick;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_WRITE;
    req_bus.elem_index  = '0;
    req_bus.write_value = '0;
    req_bus.new_length  = '0;
    rsp_bus.ready       = 1'b0;
    rst_n               = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty array: out-of-range read, refused pop front, harmless pop back,
    // sort and erase; resizes above the depth
    send_req(REQ_READ, 6'd0, 32'd0, 7'd0);
    send_req(REQ_POP_HEAD, 6'd0, 32'd0, 7'd0);
    send_req(REQ_POP_BACK, 6'd0, 32'd0, 7'd0);
    send_req(REQ_SORT, 6'd0, 32'd0, 7'd0);
    send_req(REQ_ERASE, 6'd0, 32'd0, 7'd0);
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd65);
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd127);
    // Grow from empty to full depth, load the extremes, resize to the same length
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd64);
    send_req(REQ_WRITE, 6'd63, 32'h7FFF_FFFF, 7'd0);
    send_req(REQ_WRITE, 6'd0, 32'h8000_0000, 7'd0);
    send_req(REQ_WRITE, 6'd1, 32'hFFFF_FFFF, 7'd0);
    send_req(REQ_READ, 6'd63, 32'd0, 7'd0);
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd64);
    // Full-depth sort, then read both ends
    send_req(REQ_SORT, 6'd0, 32'd0, 7'd0);
    send_req(REQ_READ, 6'd0, 32'd0, 7'd0);
    send_req(REQ_READ, 6'd63, 32'd0, 7'd0);
    // Pop front shifts down; the old top index is now out of range
    send_req(REQ_POP_HEAD, 6'd0, 32'd0, 7'd0);
    send_req(REQ_READ, 6'd63, 32'd0, 7'd0);
    send_req(REQ_WRITE, 6'd63, 32'd5, 7'd0);
    send_req(REQ_POP_BACK, 6'd0, 32'd0, 7'd0);
    // Shrink keeps the prefix, regrow zero-fills
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd3);
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd5);
    send_req(REQ_READ, 6'd4, 32'd0, 7'd0);
    send_req(REQ_READ, 6'd0, 32'd0, 7'd0);
    send_req(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF, 7'd127);
    send_req(REQ_ERASE, 6'd0, 32'd0, 7'd0);
    send_req(REQ_RESIZE, 6'd0, 32'd0, 7'd1);
    send_req(REQ_SORT, 6'd0, 32'd0, 7'd0);
    drain_results();

    // Random requests in bursts; now and then let everything drain first
    burst_left = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 39) == 0) drain_results();
        else if ($urandom_range(0, 3) != 0) hold_idle($urandom_range(1, 8));
      end
      burst_left--;

      // Random filler in every field; the request type decides which matter
      idx  = IDX_W'($urandom);
      wval = $urandom;
      nlen = LEN_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = REQ_WRITE;
      else if (pick < 59) op = REQ_READ;
      else if (pick < 70) op = REQ_RESIZE;
      else if (pick < 77) op = REQ_POP_BACK;
      else if (pick < 85) op = REQ_POP_HEAD;
      else if (pick < 90) op = REQ_SORT;
      else if (pick < 93) op = REQ_ERASE;
      else if (pick < 95) op = REQ_UNUSED;
      else                op = REQ_RESIZE;

      // Mostly land on live entries
      if (model_length != 0 && $urandom_range(0, 9) != 0)
        idx = IDX_W'($urandom_range(0, int'(model_length) - 1));

      // Small values give duplicates for the sort; extremes test signed order
      case ($urandom_range(0, 3))
        0: wval = int'($urandom_range(0, 8)) - 4;
        1: wval = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 2)
                                              : 32'h8000_0000 + $urandom_range(0, 2);
        default: ;
      endcase

      // Keep most arrays short so sorts stay cheap; a few full and oversize
      if (op == REQ_RESIZE) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)      nlen = LEN_W'($urandom_range(0, 12));
        else if (pick < 85) nlen = LEN_W'($urandom_range(13, 40));
        else if (pick < 94) nlen = LEN_W'($urandom_range(41, DEPTH));
        else                nlen = LEN_W'($urandom_range(DEPTH + 1, 127));
      end

      send_req(op, idx, wval, nlen);
    end

    drain_results();
    // Every request gives one result, so anything arriving now is a stray
    hold_idle(4 * DEPTH);

    $display("Covered %0d write, %0d read, %0d resize, %0d pop back, %0d pop front,",
             op_count[REQ_WRITE], op_count[REQ_READ], op_count[REQ_RESIZE],
             op_count[REQ_POP_BACK], op_count[REQ_POP_HEAD]);
    $display("%0d sort, %0d erase, %0d unused; %0d results, %0d refused, longest sort %0d",
             op_count[REQ_SORT], op_count[REQ_ERASE], op_count[REQ_UNUSED],
             rsp_checked, refused_count, longest_sort);
    if (fail_count == 0 && pending_rsp == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
